@@ src/text_console_cursor_scroll_macros.svh @@
// Assertion macros shared by the console RTL.
// Included by the console engine, the one module that carries concurrent checks; no other dependencies.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check that is ignored while reset is held.
`define TCCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define TCCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCCS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ src/tccs_pkg.sv @@
// Shared types and constants of the text console engine.
// No dependencies; the engine, cursor logic, result buffer and testbench import it.
`timescale 1ns / 1ps

package tccs_pkg;

    localparam int MAX_COLS   = 256;
    localparam int MAX_ROWS   = 128;
    localparam int TAB_STOP   = 4;
    localparam int COL_W      = 8;
    localparam int ROW_W      = 7;
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int DEPTH      = MAX_COLS * MAX_ROWS;
    localparam int CNT_W      = ADDR_W + 1;
    localparam int CELL_W     = 16;
    localparam int NCOLS_W    = 9;
    localparam int NROWS_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0000;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       char_code;
        logic [7:0]       color;
        logic [COL_W-1:0] new_col;
        logic [ROW_W-1:0] new_row;
    } t_cmd;

    typedef struct packed {
        logic              wrote_cell;
        logic [COL_W-1:0]  cell_col;
        logic [ROW_W-1:0]  cell_row;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
        logic              cleared;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
    } t_result;

    typedef struct packed {
        t_result            res;
        logic [NROWS_W-1:0] nrows;
    } t_step;

endpackage

@@ src/tccs_stream_if.sv @@
// Valid/ready channel carrying one item of a payload type.
// Depends on nothing; the payload type comes from tccs_pkg at instantiation.
`timescale 1ns / 1ps

interface tccs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/text_console_cursor_scroll.sv @@
// Text console engine: cursor tracking, one-row scroll and clear over a 32768-cell RAM.
// Each accepted item's result is registered in a two-entry result buffer.
// Plain puts are taken one item per cycle while the result buffer has room; a scroll
// or a clear holds input off while the one RAM write port walks the store.
// Reset (synchronous, active low) zeroes the cursor, loads 80 columns and 25 rows,
// then sweeps all 32768 cells to zero before the first item is taken.
`timescale 1ns / 1ps

module text_console_cursor_scroll (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tccs_stream_if.sink                       i_cmd,
    tccs_stream_if.source                     o_res,
    input  logic                              i_cfg_we,
    input  logic [tccs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tccs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import tccs_pkg::*;
    `include "text_console_cursor_scroll_macros.svh"

    // Sequencer states. IDLE takes items; COPY moves each row up by one,
    // reading the row below and writing the read data in the next cycle;
    // FILL writes a constant over an address range (bottom row, clear, reset).
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_COPY = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;

    logic [1:0]            r_state;
    logic [CNT_W-1:0]      r_ptr;
    logic [CNT_W-1:0]      r_end;
    logic [CNT_W-1:0]      n_ptr;
    logic [CELL_W-1:0]     r_fill_val;
    logic [NROWS_W-1:0]    r_nr;
    logic                  r_cp_valid;
    logic [ADDR_W-1:0]     r_cp_dst;

    logic [CFG_DATA_W-1:0] r_columns;
    logic [NROWS_W-1:0]    r_rows;
    logic [COL_W-1:0]      r_cur_col;
    logic [ROW_W-1:0]      r_cur_row;

    t_step                 step;
    logic                  q_room;
    logic                  acc;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [CELL_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [CELL_W-1:0]     ram_rdata;

    // Items are taken only while the sequencer is idle and the result buffer
    // has a free slot, so a finished result may still be waiting downstream.
    assign i_cmd.ready = (r_state == S_IDLE) && q_room;
    assign acc         = i_cmd.valid && i_cmd.ready;
    assign n_ptr       = r_ptr + CNT_W'(1);
    assign ram_raddr   = r_ptr[ADDR_W-1:0];

    tccs_cursor u_cursor (
        .i_item    (i_cmd.data),
        .i_cur_col (r_cur_col),
        .i_cur_row (r_cur_row),
        .i_columns (r_columns),
        .i_rows    (r_rows),
        .o_step    (step)
    );

    tccs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc),
        .i_item  (step.res),
        .o_room  (q_room),
        .o_res   (o_res)
    );

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The single write port is shared. A pending copy write wins, then the
    // fill sweep, then the cell written by an accepted put. The states keep
    // these apart; the order only documents the intent.
    always_comb begin
        priority if (r_cp_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_cp_dst;
            ram_wdata = ram_rdata;
        end else if (r_state == S_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = r_ptr[ADDR_W-1:0];
            ram_wdata = r_fill_val;
        end else if (acc && step.res.wrote_cell) begin
            ram_we    = 1'b1;
            ram_waddr = {step.res.cell_row, step.res.cell_col};
            ram_wdata = step.res.cell_value;
        end else begin
            ram_we    = 1'b0;
            ram_waddr = '0;
            ram_wdata = '0;
        end
    end

    // Configuration registers; the user must write them only while idle (not enforced).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= CFG_DATA_W'(80);
            r_rows    <= NROWS_W'(25);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_COLUMNS) begin
                r_columns <= i_cfg_data;
            end else begin
                r_rows <= i_cfg_data[NROWS_W-1:0];
            end
        end
    end

    // Cursor position; the step logic already folds in wrap, scroll and clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
        end else if (acc) begin
            r_cur_col <= step.res.cursor_col;
            r_cur_row <= step.res.cursor_row;
        end
    end

    // Store sequencer. A scroll starts reading at the second row and stops
    // once the last used row has been read; the final copy write lands in
    // the cycle that turns to FILL, which then blanks the bottom used row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FILL;
            r_ptr      <= '0;
            r_end      <= CNT_W'(DEPTH);
            r_fill_val <= RESET_CELL;
            r_nr       <= NROWS_W'(1);
            r_cp_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cp_valid <= 1'b0;
                    if (acc && step.res.scrolled) begin
                        r_state <= S_COPY;
                        r_ptr   <= CNT_W'(MAX_COLS);
                        r_end   <= CNT_W'({step.nrows, {COL_W{1'b0}}});
                        r_nr    <= step.nrows;
                    end else if (acc && step.res.cleared) begin
                        r_state    <= S_FILL;
                        r_ptr      <= '0;
                        r_end      <= CNT_W'(DEPTH);
                        r_fill_val <= BLANK_CELL;
                    end
                end
                S_COPY: begin
                    if (r_ptr != r_end) begin
                        r_cp_valid <= 1'b1;
                        r_cp_dst   <= ADDR_W'(r_ptr - CNT_W'(MAX_COLS));
                        r_ptr      <= n_ptr;
                    end else begin
                        r_cp_valid <= 1'b0;
                        r_state    <= S_FILL;
                        r_ptr      <= CNT_W'({r_nr - NROWS_W'(1), {COL_W{1'b0}}});
                        r_end      <= CNT_W'({r_nr, {COL_W{1'b0}}});
                        r_fill_val <= BLANK_CELL;
                    end
                end
                S_FILL: begin
                    r_cp_valid <= 1'b0;
                    r_ptr      <= n_ptr;
                    if (n_ptr == r_end) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_cp_valid <= 1'b0;
                    r_state    <= S_IDLE;
                end
            endcase
        end
    end

    `TCCS_ASSERT(a_ready_only_idle, i_clk, i_rst_n,
        i_cmd.ready |-> r_state == S_IDLE,
        "item taken while the store sequencer is busy")
    `TCCS_ASSERT(a_copy_write_in_walk, i_clk, i_rst_n,
        r_cp_valid |-> r_state == S_COPY || r_state == S_FILL,
        "copy write outside a scroll")
    `TCCS_ASSERT(a_scroll_starts_copy, i_clk, i_rst_n,
        acc && step.res.scrolled |=> r_state == S_COPY,
        "scrolling item did not start the row copy")
    `TCCS_ASSERT(a_clear_starts_fill, i_clk, i_rst_n,
        acc && step.res.cleared |=> r_state == S_FILL && r_ptr == '0,
        "clear did not start a sweep at the first cell")

endmodule

@@ src/tccs_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
`timescale 1ns / 1ps

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/tccs_cursor.sv @@
// Cursor step logic: decodes one item against the current cursor and sizes.
// Depends on tccs_pkg for the item, result and step types.
`timescale 1ns / 1ps

module tccs_cursor (
    input  tccs_pkg::t_cmd                    i_item,
    input  logic [tccs_pkg::COL_W-1:0]        i_cur_col,
    input  logic [tccs_pkg::ROW_W-1:0]        i_cur_row,
    input  logic [tccs_pkg::CFG_DATA_W-1:0]   i_columns,
    input  logic [tccs_pkg::NROWS_W-1:0]      i_rows,
    output tccs_pkg::t_step                   o_step
);
    import tccs_pkg::*;

    logic [NCOLS_W-1:0] ncols;
    logic [NROWS_W-1:0] nrows;
    logic               in_area;
    logic [NCOLS_W-1:0] col_p1;
    logic [NROWS_W-1:0] row_p1;
    logic               row_wrap;
    logic [ROW_W-1:0]   nl_row;
    logic [NCOLS_W-1:0] tab_t;
    logic [COL_W-1:0]   bs_col;
    logic               bs_in_area;

    // Out-of-range sizes are clamped: zero acts as one, too large as the maximum.
    assign ncols = (i_columns == '0) ? NCOLS_W'(1) :
                   (i_columns > NCOLS_W'(MAX_COLS)) ? NCOLS_W'(MAX_COLS) : i_columns;
    assign nrows = (i_rows == '0) ? NROWS_W'(1) :
                   (i_rows > NROWS_W'(MAX_ROWS)) ? NROWS_W'(MAX_ROWS) : i_rows;

    assign in_area    = ({1'b0, i_cur_col} < ncols) && ({1'b0, i_cur_row} < nrows);
    assign col_p1     = {1'b0, i_cur_col} + NCOLS_W'(1);
    assign row_p1     = {1'b0, i_cur_row} + NROWS_W'(1);
    assign row_wrap   = row_p1 >= nrows;
    assign nl_row     = row_wrap ? ROW_W'(nrows - NROWS_W'(1)) : row_p1[ROW_W-1:0];
    assign tab_t      = NCOLS_W'((i_cur_col / TAB_STOP + 1) * TAB_STOP);
    assign bs_col     = (i_cur_col == '0) ? COL_W'(ncols - NCOLS_W'(1))
                                          : i_cur_col - COL_W'(1);
    assign bs_in_area = ({1'b0, bs_col} < ncols) && ({1'b0, i_cur_row} < nrows);

    always_comb begin
        o_step.nrows          = nrows;
        o_step.res            = '0;
        o_step.res.cursor_col = i_cur_col;
        o_step.res.cursor_row = i_cur_row;

        unique case (i_item.op)
            OP_PUT: begin
                unique case (i_item.char_code)
                    CH_NUL: begin
                    end
                    CH_TAB: begin
                        if (tab_t >= ncols) begin
                            o_step.res.cursor_col = '0;
                            o_step.res.cursor_row = nl_row;
                            o_step.res.scrolled   = row_wrap;
                        end else begin
                            o_step.res.cursor_col = tab_t[COL_W-1:0];
                        end
                    end
                    CH_BS: begin
                        o_step.res.cursor_col = bs_col;
                        if (bs_in_area) begin
                            o_step.res.wrote_cell = 1'b1;
                            o_step.res.cell_col   = bs_col;
                            o_step.res.cell_row   = i_cur_row;
                            o_step.res.cell_value = BLANK_CELL;
                        end
                    end
                    CH_NL: begin
                        o_step.res.cursor_col = '0;
                        o_step.res.cursor_row = nl_row;
                        o_step.res.scrolled   = row_wrap;
                    end
                    default: begin
                        if (in_area) begin
                            o_step.res.wrote_cell = 1'b1;
                            o_step.res.cell_col   = i_cur_col;
                            o_step.res.cell_row   = i_cur_row;
                            o_step.res.cell_value = {i_item.color, i_item.char_code};
                        end
                        if (col_p1 >= ncols) begin
                            o_step.res.cursor_col = '0;
                            o_step.res.cursor_row = nl_row;
                            o_step.res.scrolled   = row_wrap;
                        end else begin
                            o_step.res.cursor_col = col_p1[COL_W-1:0];
                        end
                    end
                endcase
            end
            OP_SET: begin
                o_step.res.cursor_col = i_item.new_col;
                o_step.res.cursor_row = i_item.new_row;
            end
            OP_CLEAR: begin
                o_step.res.cleared    = 1'b1;
                o_step.res.cursor_col = '0;
                o_step.res.cursor_row = '0;
            end
            default: begin
            end
        endcase
    end
endmodule

@@ src/tccs_outq.sv @@
// Two-entry result buffer: an output register backed by a skid register.
// Depends on tccs_pkg for the result type and on tccs_stream_if.
`timescale 1ns / 1ps

module tccs_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tccs_pkg::t_result i_item,
    output logic              o_room,
    tccs_stream_if.source     o_res
);
    import tccs_pkg::*;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    pop;

    assign pop         = r_out_valid && o_res.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;
    // A push is only offered while the skid register is free.
    assign o_room      = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_out       <= i_item;
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (i_push) begin
            r_skid       <= i_item;
            r_skid_valid <= 1'b1;
        end
    end
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the text console engine: cursor moves, cell writes,
// one-row scrolls and clears, checked item by item against a predictor in this file.
// Depends on tccs_pkg, tccs_stream_if and text_console_cursor_scroll from the RTL.
`timescale 1ns / 1ps

module tb_top;
    import tccs_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int STALL_MAX      = 7;
    // The slowest stall is a scroll over 128 rows or a clear of the whole store.
    // The sweep after reset is as long as a clear. The limit leaves plenty of room.
    localparam int WATCHDOG_LIMIT = 150000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_ITEMS    = 120;

    // Op code 3 is not used by the block; it only reports the cursor.
    localparam logic [1:0] OP_NONE = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    tccs_stream_if #(.T(t_cmd))    cmd_if ();
    tccs_stream_if #(.T(t_result)) res_if ();

    text_console_cursor_scroll DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Predicted state of the console: register contents as written and the cursor.
    // The cell store itself is never reported, so it is not mirrored here.
    logic [NCOLS_W-1:0] model_cols    = 9'd80;
    logic [NROWS_W-1:0] model_rows    = 8'd25;
    logic [COL_W-1:0]   model_cur_col = '0;
    logic [ROW_W-1:0]   model_cur_row = '0;

    // Results still owed by the block, oldest first.
    t_result pending_results[$];

    // Idling controls: the sender and the receiver each draw a wait per item
    // while their flag is set. A hold request makes the receiver stall for a
    // long stretch that it counts itself.
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    bit hold_req     = 1'b0;

    int err_cnt      = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_writes     = 0;
    int n_scrolls    = 0;
    int n_clears     = 0;
    int n_settings   = 0;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Registers out of range are clamped by the block: 0 acts as 1 and anything
    // above the store size acts as the store size.
    function automatic int active_cols();
        if (model_cols == 0) return 1;
        if (model_cols > MAX_COLS) return MAX_COLS;
        return int'(model_cols);
    endfunction

    function automatic int active_rows();
        if (model_rows == 0) return 1;
        if (model_rows > MAX_ROWS) return MAX_ROWS;
        return int'(model_rows);
    endfunction

    // Moves the cursor to column 0 of the next row. Leaving the bottom row in use
    // scrolls the area up one row and parks the cursor on the bottom row, even when
    // the cursor started below the area in use.
    function automatic bit advance_row(inout int col, inout int row, input int nrows);
        col = 0;
        if (row + 1 >= nrows) begin
            row = nrows - 1;
            return 1'b1;
        end
        row = row + 1;
        return 1'b0;
    endfunction

    // Works out the result of one accepted item and updates the predicted cursor.
    function automatic t_result console_next(input t_cmd c);
        int      ncols;
        int      nrows;
        int      col;
        int      row;
        int      stop;
        t_result r;
        ncols = active_cols();
        nrows = active_rows();
        col   = model_cur_col;
        row   = model_cur_row;
        r     = '0;
        case (c.op)
            OP_PUT: begin
                case (c.char_code)
                    CH_NUL: ;   // NUL leaves everything as it is.
                    CH_TAB: begin
                        stop = (col / TAB_STOP + 1) * TAB_STOP;
                        if (stop >= ncols) r.scrolled = advance_row(col, row, nrows);
                        else col = stop;
                    end
                    CH_BS: begin
                        // Column 0 wraps to the last column of the same row.
                        col = (col == 0) ? ncols - 1 : col - 1;
                        if (col < ncols && row < nrows) begin
                            r.wrote_cell = 1'b1;
                            r.cell_col   = col[COL_W-1:0];
                            r.cell_row   = row[ROW_W-1:0];
                            r.cell_value = BLANK_CELL;
                        end
                    end
                    CH_NL: begin
                        r.scrolled = advance_row(col, row, nrows);
                    end
                    default: begin
                        // A cursor outside the area in use writes nothing but still moves.
                        if (col < ncols && row < nrows) begin
                            r.wrote_cell = 1'b1;
                            r.cell_col   = col[COL_W-1:0];
                            r.cell_row   = row[ROW_W-1:0];
                            r.cell_value = {c.color, c.char_code};
                        end
                        if (col + 1 >= ncols) r.scrolled = advance_row(col, row, nrows);
                        else col = col + 1;
                    end
                endcase
            end
            OP_SET: begin
                col = c.new_col;
                row = c.new_row;
            end
            OP_CLEAR: begin
                col       = 0;
                row       = 0;
                r.cleared = 1'b1;
            end
            default: ;
        endcase
        model_cur_col = col[COL_W-1:0];
        model_cur_row = row[ROW_W-1:0];
        r.cursor_col  = model_cur_col;
        r.cursor_row  = model_cur_row;
        return r;
    endfunction

    function automatic t_cmd make_cmd(input logic [1:0] op, input logic [7:0] ch,
                                      input logic [7:0] color, input logic [7:0] col,
                                      input logic [6:0] row);
        t_cmd c;
        c.op        = op;
        c.char_code = ch;
        c.color     = color;
        c.new_col   = col;
        c.new_row   = row;
        return c;
    endfunction

    // Random item, mostly text with line breaks, tabs and backspaces, and now and
    // then a cursor move, an unused op or (rarely, since it sweeps the whole store) a clear.
    // Fields that the op ignores still carry random values.
    function automatic t_cmd random_cmd(input bit allow_clear);
        t_cmd c;
        int   pick;
        c.op        = OP_PUT;
        c.char_code = 8'($urandom_range(0, 255));
        c.color     = 8'($urandom_range(0, 255));
        c.new_col   = 8'($urandom_range(0, 255));
        c.new_row   = 7'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (allow_clear && $urandom_range(0, 799) == 0) begin
            c.op = OP_CLEAR;
        end else if (pick < 8) begin
            c.op = OP_SET;
            // Most moves land inside the area in use; the rest use the whole field.
            if ($urandom_range(0, 3) != 0) begin
                c.new_col = 8'($urandom_range(0, active_cols() - 1));
                c.new_row = 7'($urandom_range(0, active_rows() - 1));
            end
        end else if (pick < 10) begin
            c.op = OP_NONE;
        end else if (pick < 20) begin
            c.char_code = CH_NL;
        end else if (pick < 28) begin
            c.char_code = CH_TAB;
        end else if (pick < 35) begin
            c.char_code = CH_BS;
        end else if (pick < 37) begin
            c.char_code = CH_NUL;
        end
        return c;
    endfunction

    // Offers one item and returns at the edge that accepts it. Valid stays high
    // afterwards, so a caller that does anything but send again must lower it first.
    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = send_idle_on ? $urandom_range(0, STALL_MAX) : 0;
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        @(posedge i_clk);
        while (!(cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1)) @(posedge i_clk);
        pending_results.push_back(console_next(c));
        n_sent++;
    endtask

    // Stops offering items and waits until every owed result has come back.
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes both registers while the block is idle. A scroll or a clear can still
    // be walking the store after its result has left, so the write waits until the
    // block is ready for a new item again.
    task automatic configure(input int cols, input int rows);
        drain();
        while (cmd_if.ready !== 1'b1) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_COLUMNS;
        cfg_data <= cols[CFG_DATA_W-1:0];
        @(posedge i_clk);
        model_cols = cols[NCOLS_W-1:0];
        cfg_idx  <= REG_ROWS;
        cfg_data <= CFG_DATA_W'(rows[NROWS_W-1:0]);
        @(posedge i_clk);
        model_rows = rows[NROWS_W-1:0];
        cfg_we   <= 1'b0;
        n_settings++;
    endtask

    function automatic void compare_field(input string name, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic check_result(input t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            $error("result arrived with no item waiting for it: %p", got);
            err_cnt++;
            return;
        end
        want = pending_results.pop_front();
        n_checked++;
        n_writes  += want.wrote_cell;
        n_scrolls += want.scrolled;
        n_clears  += want.cleared;
        compare_field("wrote_cell", 16'(want.wrote_cell), 16'(got.wrote_cell));
        compare_field("cell_col",   16'(want.cell_col),   16'(got.cell_col));
        compare_field("cell_row",   16'(want.cell_row),   16'(got.cell_row));
        compare_field("cell_value", want.cell_value,      got.cell_value);
        compare_field("scrolled",   16'(want.scrolled),   16'(got.scrolled));
        compare_field("cleared",    16'(want.cleared),    16'(got.cleared));
        compare_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
        compare_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
    endtask

    // Result side: draws a stall per item, or takes a long hold when asked, then
    // takes one result and checks it against the oldest prediction.
    initial begin : result_checker
        int stall;
        forever begin
            stall = recv_idle_on ? $urandom_range(0, STALL_MAX) : 0;
            if (hold_req) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1))
                @(posedge i_clk);
            check_result(res_if.data);
        end
    end

    // Ends the run if no item moves on either side for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
                (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles, %0d results owed.",
                         WATCHDOG_LIMIT, pending_results.size());
                $display("** text_console_cursor_scroll: FAILED **");
                $finish;
            end
        end
    end

    // Reset geometry of 80 x 25: every kind of put, the unused op, and cursor
    // moves to the last cell and outside the area in use. The first item waits
    // out the clearing sweep that follows reset.
    task automatic test_default_geometry();
        send_cmd(make_cmd(OP_PUT, 8'h41, 8'h1F, 8'h00, 7'h00));
        send_cmd(make_cmd(OP_PUT, 8'hFF, 8'hFF, 8'hFF, 7'h7F));
        send_cmd(make_cmd(OP_PUT, CH_NUL, 8'h00, 8'h00, 7'h00));
        send_cmd(make_cmd(OP_PUT, CH_TAB, 8'h00, 8'h00, 7'h00));
        send_cmd(make_cmd(OP_PUT, CH_BS, 8'h00, 8'h00, 7'h00));
        send_cmd(make_cmd(OP_PUT, CH_NL, 8'h00, 8'h00, 7'h00));
        // Backspace from column 0 wraps to the last column of the same row.
        send_cmd(make_cmd(OP_PUT, CH_BS, 8'h00, 8'h00, 7'h00));
        send_cmd(make_cmd(OP_NONE, 8'h55, 8'hAA, 8'h55, 7'h2A));
        // The last cell of the screen: the write wraps and scrolls.
        send_cmd(make_cmd(OP_SET, 8'h00, 8'h00, 8'd79, 7'd24));
        send_cmd(make_cmd(OP_PUT, 8'h7E, 8'h80, 8'h00, 7'h00));
        // Far outside the area: no write, but the cursor still wraps and scrolls.
        send_cmd(make_cmd(OP_SET, 8'h00, 8'h00, 8'd255, 7'd127));
        send_cmd(make_cmd(OP_PUT, 8'h20, 8'h01, 8'h00, 7'h00));
        send_cmd(make_cmd(OP_SET, 8'h00, 8'h00, 8'd200, 7'd10));
        send_cmd(make_cmd(OP_PUT, CH_BS, 8'h00, 8'h00, 7'h00));
    endtask

    task automatic test_clear_store();
        send_cmd(make_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, 7'h00));
    endtask

    // Register extremes: zero, all ones, one past the store size, and one.
    task automatic test_register_extremes();
        configure(0, 0);
        send_cmd(make_cmd(OP_PUT, 8'h61, 8'h0F, 8'h00, 7'h00));
        send_cmd(make_cmd(OP_PUT, CH_TAB, 8'h00, 8'h00, 7'h00));
        send_cmd(make_cmd(OP_PUT, CH_BS, 8'h00, 8'h00, 7'h00));
        // The full store: a tab that reaches the width wraps and scrolls all 128 rows.
        configure((1 << NCOLS_W) - 1, (1 << NROWS_W) - 1);
        send_cmd(make_cmd(OP_SET, 8'h00, 8'h00, 8'd252, 7'd127));
        send_cmd(make_cmd(OP_PUT, CH_TAB, 8'h00, 8'h00, 7'h00));
        configure(MAX_COLS + 1, MAX_ROWS);
        send_cmd(make_cmd(OP_SET, 8'h00, 8'h00, 8'd255, 7'd126));
        send_cmd(make_cmd(OP_PUT, 8'h51, 8'hF0, 8'h00, 7'h00));
        configure(1, 1);
        send_cmd(make_cmd(OP_PUT, 8'h5A, 8'h3C, 8'h00, 7'h00));
    endtask

    // The receiver holds off for a long stretch while items keep coming back to
    // back, so the block fills up and has to stall its input.
    task automatic test_output_backpressure();
        configure(40, 3);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        hold_req     = 1'b1;
        repeat (40) send_cmd(random_cmd(1'b0));
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    // The sender stops until every owed result is back, then carries on.
    task automatic test_sender_pause();
        repeat (20) send_cmd(random_cmd(1'b0));
        drain();
        repeat (20) send_cmd(random_cmd(1'b0));
    endtask

    // Random traffic in phases, each with its own geometry and idling mix. Rows
    // stay small in most phases, since every scroll walks the whole area in use.
    task automatic test_random_traffic();
        int phase;
        int cols;
        int rows;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0:       cols = $urandom_range(0, 8);
                1:       cols = $urandom_range(1, 80);
                2:       cols = $urandom_range(0, (1 << NCOLS_W) - 1);
                3:       cols = MAX_COLS;
                4:       cols = (1 << NCOLS_W) - 1;
                default: cols = $urandom_range(4, 40);
            endcase
            rows = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
            configure(cols, rows);
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS) send_cmd(random_cmd(1'b1));
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    initial begin : stimulus
        i_rst_n      <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;
        cfg_we       <= 1'b0;
        cfg_idx      <= '0;
        cfg_data     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_geometry();
        test_clear_store();
        test_register_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();

        // Let any stray result show up before the verdict.
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items in %0d register settings: %0d cells written,",
                 n_sent, n_settings, n_writes);
        $display("%0d scrolls and %0d clears; %0d results checked, %0d mismatches.",
                 n_scrolls, n_clears, n_checked, err_cnt);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("** text_console_cursor_scroll: PASSED **");
        end else begin
            $display("** text_console_cursor_scroll: FAILED **");
        end
        $finish;
    end

endmodule
